// File: rtl/wildcard_glob_matcher_defines.svh
// assertion macros shared by the matcher rtl
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

`ifndef ASSERT_OFF
`define WGM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WGM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WGM_ASSERT(label, prop, msg)
`define WGM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/wgm_pkg.sv
package wgm_pkg;

    localparam int PATTERN_MAX_DEF = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_REGS   = 4;
    localparam int PAT_BYTES  = PAT_REGS * 8;
    localparam int LEN_REG_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

    // request opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // pattern wildcards
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_ONE  = 8'h3F;

    typedef logic [7:0] byte_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic step;   // name byte accepted
        logic clear;  // end of name accepted
    } cell_ctrl_t;

endpackage

// File: rtl/wgm_if.sv
interface wgm_req_if;
    import wgm_pkg::*;
    logic  valid;
    logic  ready;
    logic  op;
    byte_t name_byte;

    modport source (output valid, output op, output name_byte, input ready);
    modport sink   (input valid, input op, input name_byte, output ready);
endinterface

interface wgm_rsp_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

// File: rtl/wgm_cfg.sv
module wgm_cfg
    import wgm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [CFG_IDX_W-1:0]                cfg_idx,
    input  logic [CFG_DATA_W-1:0]               cfg_data,
    output byte_t [PATTERN_MAX-1:0]             pat_bytes,
    output logic  [PATTERN_MAX-1:0]             pos_en,
    output logic  [$clog2(PATTERN_MAX+1)-1:0]   len_sat
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pat_reg;
    logic [LEN_REG_W-1:0]                len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            len_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_PAT_0_7:   pat_reg[0] <= cfg_data;
                REG_PAT_8_15:  pat_reg[1] <= cfg_data;
                REG_PAT_16_23: pat_reg[2] <= cfg_data;
                REG_PAT_24_31: pat_reg[3] <= cfg_data;
                REG_PAT_LEN:   len_reg    <= cfg_data[LEN_REG_W-1:0];
                default:       ;
            endcase
        end
    end

    // length saturates at PATTERN_MAX, the count of pattern cells
    assign len_sat = (len_reg > LEN_REG_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                        : len_reg[LEN_W-1:0];

    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_pos
        if (i < PAT_BYTES)
        begin : g_reg
            assign pat_bytes[i] = pat_reg[i / 8][(i % 8) * 8 +: 8];
        end
        else
        begin : g_zero
            assign pat_bytes[i] = '0;
        end
        assign pos_en[i] = (LEN_W'(i) < len_sat);
    end

endmodule

// File: rtl/wgm_cell.sv
module wgm_cell
    import wgm_pkg::*;
#(
    parameter bit RESET_LIVE = 1'b0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       en,
    input  byte_t      pat_byte,
    input  byte_t      name_byte,
    input  logic       close_in,
    input  logic       adv_in,
    input  logic       nclose_in,
    output logic       cur,
    output logic       close_out,
    output logic       adv_out,
    output logic       nclose_out,
    output logic       live
);

    logic live_reg;
    logic live_next;
    logic is_star;
    logic hit;
    logic nxt;

    always_comb
    begin
        is_star    = (pat_byte == CHAR_STAR);
        hit        = (pat_byte == CHAR_ONE) || (pat_byte == name_byte);
        // closure of the stored set with the current pattern
        cur        = live_reg | close_in;
        close_out  = en & is_star & cur;
        // byte transition: a star stays put, anything else advances on a hit
        adv_out    = en & cur & ~is_star & hit;
        nxt        = (en & cur & is_star) | adv_in;
        // closure of the new set
        live_next  = nxt | nclose_in;
        nclose_out = en & is_star & live_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= RESET_LIVE;
        end
        else if (ctrl.clear)
        begin
            live_reg <= RESET_LIVE;
        end
        else if (ctrl.step)
        begin
            live_reg <= live_next;
        end
    end

    assign live = live_reg;

endmodule

// File: rtl/wildcard_glob_matcher.sv
// wildcard glob matcher
//
// req channel: one request per name byte (op = byte) and one closing request
// (op = end) per name; an end request with no bytes before it is an empty name.
// rsp channel: one response per end request, matched = 1 when the whole name
// fits the pattern ('*' any run, '?' one byte, other bytes literal).
// cfg port: write-only pattern registers, indices 0..3 hold pattern bytes,
// index 4 the length; the user must write only while no request is in flight, the block has no check.
//
// throughput: one request per cycle, back to back, while no response is held.
// the live-position set sits in a row of PATTERN_MAX+1 cells; each cycle the
// star closure and byte step ripple once along it: one byte absorbed per clock.
// the response is registered, valid the cycle after the end request.
// a pending response holds while rsp.ready is low; req.ready stays high as long
// as the output register is free or is being emptied in the same cycle.
// reset: pattern and length clear to zero, only position zero is live, no
// response is pending.
`include "wildcard_glob_matcher_defines.svh"

module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    wgm_req_if.sink               req,
    wgm_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // pattern view from the register file
    byte_t [PATTERN_MAX-1:0] pat_bytes;
    logic  [PATTERN_MAX-1:0] pos_en;
    logic  [LEN_W-1:0]       len_sat;

    // neighbor links along the cell row
    logic [PATTERN_MAX:0] close_c;
    logic [PATTERN_MAX:0] adv_c;
    logic [PATTERN_MAX:0] nclose_c;
    logic [PATTERN_MAX:0] cur_bits;
    logic [PATTERN_MAX:0] live_bits;

    cell_ctrl_t ctrl;
    logic       req_fire;
    logic       matched_now;

    logic       rsp_valid_reg;
    logic       matched_reg;

    wgm_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .pat_bytes (pat_bytes),
        .pos_en    (pos_en),
        .len_sat   (len_sat)
    );

    // request handshake and broadcast command
    assign req_fire   = req.valid && req.ready;
    assign ctrl.step  = req_fire && (req.op == OP_BYTE);
    assign ctrl.clear = req_fire && (req.op == OP_END);

    // nothing feeds the head of the row
    assign close_c[0]  = 1'b0;
    assign adv_c[0]    = 1'b0;
    assign nclose_c[0] = 1'b0;

    for (genvar g = 0; g <= PATTERN_MAX; g++)
    begin : g_cell
        if (g < PATTERN_MAX)
        begin : g_pos
            wgm_cell #(
                .RESET_LIVE (g == 0)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .en         (pos_en[g]),
                .pat_byte   (pat_bytes[g]),
                .name_byte  (req.name_byte),
                .close_in   (close_c[g]),
                .adv_in     (adv_c[g]),
                .nclose_in  (nclose_c[g]),
                .cur        (cur_bits[g]),
                .close_out  (close_c[g+1]),
                .adv_out    (adv_c[g+1]),
                .nclose_out (nclose_c[g+1]),
                .live       (live_bits[g])
            );
        end
        else
        begin : g_tail
            // the position past the last pattern byte only collects
            wgm_cell #(
                .RESET_LIVE (1'b0)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .en         (1'b0),
                .pat_byte   ('0),
                .name_byte  (req.name_byte),
                .close_in   (close_c[g]),
                .adv_in     (adv_c[g]),
                .nclose_in  (nclose_c[g]),
                .cur        (cur_bits[g]),
                .close_out  (),
                .adv_out    (),
                .nclose_out (),
                .live       (live_bits[g])
            );
        end
    end

    // the name matched when the position after the whole pattern is live
    assign matched_now = cur_bits[len_sat];

    // output register, refilled in the same cycle it drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            matched_reg <= matched_now;
        end
    end

    assign req.ready   = !rsp_valid_reg || rsp.ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.matched = matched_reg;

    // an end request rearms the row: position zero live, the tail position clear
    `WGM_ASSERT(a_end_rearms, ctrl.clear |=> (live_bits[0] && live_bits[PATTERN_MAX] == 1'b0), "row not rearmed after end request")
    // every end request yields a response on the next cycle
    `WGM_ASSERT(a_end_responds, ctrl.clear |=> rsp.valid, "end request produced no response")
    // a byte request never creates a response of its own
    `WGM_ASSERT(a_byte_silent, (ctrl.step && (!rsp_valid_reg || rsp.ready)) |=> !rsp.valid, "byte request produced a response")
    // no cell command while the output register is stuck full
    `WGM_ASSERT_ALWAYS(a_no_cmd_when_full, (rsp_valid_reg && !rsp.ready) |-> !(ctrl.step || ctrl.clear), "request taken while response stalled")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import wgm_pkg::*;

    localparam int PMAX          = PATTERN_MAX_DEF;
    localparam int IDLE_LIMIT    = 4000;   // cycles with no handshake before giving up
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off for backpressure
    localparam int RANDOM_PHASES = 24;
    localparam int PHASE_REQS    = 28;     // requests per pattern setting, roughly
    localparam int DRAIN_CYCLES  = 3;      // response is registered, valid the cycle after the end request

    // first index past the defined registers
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_PAT_LEN + 3'd1;

    typedef logic [PMAX:0] live_set_t;
    typedef byte_t byte_q_t[$];

    typedef struct packed {
        logic  op;
        byte_t name_byte;
    } name_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    wgm_req_if req ();
    wgm_rsp_if rsp ();

    wildcard_glob_matcher #(
        .PATTERN_MAX (PMAX)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the matcher: pattern registers and the live-position set
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] pat_words [PAT_REGS];
    logic [LEN_REG_W-1:0]  len_reg;
    live_set_t             live_set;

    name_req_t     pending_reqs [$];     // requests not yet handed to the driver
    logic          expected_matches [$]; // verdicts owed by the block, oldest first
    int unsigned   reqs_in_flight = 0;   // queued or on the bus, not yet accepted
    int unsigned   failures = 0;
    int unsigned   send_idle_pct;
    int unsigned   recv_idle_pct;

    // lengths above the maximum saturate
    function automatic int unsigned used_length();
        return (len_reg > PMAX) ? PMAX : int'(len_reg);
    endfunction

    // positions past the register file read as zero
    function automatic byte_t pattern_at(input int unsigned i);
        if (i >= PAT_BYTES)
            return 8'h00;
        return pat_words[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // a live star also makes the position after it live
    function automatic live_set_t close_stars(input live_set_t s);
        int unsigned n;
        n = used_length();
        for (int unsigned i = 0; i < n; i++)
            if (s[i] && pattern_at(i) == CHAR_STAR)
                s[i + 1] = 1'b1;
        return s;
    endfunction

    // apply one accepted request to the shadow state;
    // returns 1 when the request owes a verdict, which lands in verdict
    function automatic bit absorb_request(input name_req_t r, output logic verdict);
        live_set_t   cur;
        live_set_t   nxt;
        int unsigned n;
        byte_t       p;
        n = used_length();
        cur = close_stars(live_set);
        verdict = cur[n];
        if (r.op == OP_END)
        begin
            live_set = live_set_t'(1);
            return 1'b1;
        end
        nxt = '0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (cur[i])
            begin
                p = pattern_at(i);
                // star stays put and eats the byte, anything else advances
                if (p == CHAR_STAR)
                    nxt[i] = 1'b1;
                else if (p == CHAR_ONE || p == r.name_byte)
                    nxt[i + 1] = 1'b1;
            end
        end
        live_set = close_stars(nxt);
        return 1'b0;
    endfunction

    function automatic void mirror_config(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PAT_0_7:   pat_words[0] = data;
            REG_PAT_8_15:  pat_words[1] = data;
            REG_PAT_16_23: pat_words[2] = data;
            REG_PAT_24_31: pat_words[3] = data;
            REG_PAT_LEN:   len_reg = data[LEN_REG_W-1:0];
            default:       ;  // unknown index, write dropped
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        failures++;
    endtask

    // ------------------------------------------------------------------
    // request driver: holds the payload until accepted, idles at random
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            req.valid <= 1'b0;
        else if (!req.valid || req.ready)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                req.valid     <= 1'b1;
                req.op        <= pending_reqs[0].op;
                req.name_byte <= pending_reqs[0].name_byte;
                void'(pending_reqs.pop_front());
            end
            else
                req.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // response receiver: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    int unsigned hold_kicks = 0;
    int unsigned hold_served = 0;

    always @(posedge clk)
    begin
        // a new kick from the stimulus starts a long hold
        if (hold_left == 0 && hold_served != hold_kicks)
        begin
            hold_served = hold_kicks;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // monitor: predicts on accepted requests, checks accepted responses,
    // and doubles as the watchdog
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;
    logic        want_match;
    logic        new_verdict;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_matches.size() == 0)
                    report_mismatch($sformatf("response matched=%0b with none pending",
                                              rsp.matched));
                else
                begin
                    want_match = expected_matches.pop_front();
                    if (rsp.matched !== want_match)
                        report_mismatch($sformatf("matched=%0b, expected %0b",
                                                  rsp.matched, want_match));
                end
            end
            if (req.valid && req.ready)
            begin
                reqs_in_flight--;
                if (absorb_request(name_req_t'{req.op, req.name_byte}, new_verdict))
                    expected_matches.insert(expected_matches.size(), new_verdict);
            end
        end
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == IDLE_LIMIT)
        begin
            $display("[%0t] timeout: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_req(input logic op, input byte_t b);
        pending_reqs.insert(pending_reqs.size(), name_req_t'{op, b});
        reqs_in_flight++;
    endfunction

    function automatic byte_q_t text_bytes(input string s);
        byte_q_t q;
        for (int k = 0; k < s.len(); k++)
            q.insert(q.size(), s[k]);
        return q;
    endfunction

    // mostly a small alphabet so names hit the pattern often
    function automatic byte_t pick_name_byte();
        case ($urandom_range(7, 0))
            0:       return byte_t'($urandom);
            1:       return CHAR_STAR;
            default: return byte_t'("a") + byte_t'($urandom_range(2, 0));
        endcase
    endfunction

    function automatic byte_t pick_pattern_byte();
        case ($urandom_range(9, 0))
            0, 1:    return CHAR_STAR;
            2, 3:    return CHAR_ONE;
            4:       return byte_t'($urandom);
            default: return byte_t'("a") + byte_t'($urandom_range(2, 0));
        endcase
    endfunction

    // random pattern; len6 is the raw length written, may exceed the maximum
    function automatic byte_q_t random_pattern(output logic [LEN_REG_W-1:0] len6);
        byte_q_t     plan;
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            len6 = LEN_REG_W'($urandom_range(6, 0));
        else if (roll < 85)
            len6 = LEN_REG_W'($urandom_range(PMAX, 7));
        else
            len6 = LEN_REG_W'($urandom_range(63, PMAX + 1));
        repeat ((len6 > PMAX) ? PMAX : len6)
            plan.insert(plan.size(), pick_pattern_byte());
        return plan;
    endfunction

    // a name built to fit the plan, sometimes damaged, sometimes pure noise;
    // returns the number of requests queued
    function automatic int unsigned queue_name(input byte_q_t plan);
        byte_q_t     name;
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 10)
        begin
            repeat ($urandom_range(6, 0))
                name.insert(name.size(), byte_t'($urandom));
        end
        else
        begin
            foreach (plan[k])
            begin
                if (plan[k] == CHAR_STAR)
                    repeat ($urandom_range(3, 0))
                        name.insert(name.size(), pick_name_byte());
                else if (plan[k] == CHAR_ONE)
                    name.insert(name.size(), byte_t'($urandom));
                else
                    name.insert(name.size(), plan[k]);
            end
            // break a quarter of them
            if (roll >= 75)
            begin
                case ($urandom_range(2, 0))
                    0: name.insert($urandom_range(name.size(), 0), pick_name_byte());
                    1: if (name.size() != 0) name.delete($urandom_range(name.size() - 1, 0));
                    default: if (name.size() != 0)
                                 name[$urandom_range(name.size() - 1, 0)] = pick_name_byte();
                endcase
            end
        end
        foreach (name[k])
            push_req(OP_BYTE, name[k]);
        push_req(OP_END, byte_t'($urandom));
        return name.size() + 1;
    endfunction

    // one register write per clock; the shadow follows at once since
    // nothing is in flight while registers change
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        mirror_config(idx, data);
    endtask

    // bytes past the plan are random garbage, they must not matter
    task automatic program_pattern(input byte_q_t plan, input logic [LEN_REG_W-1:0] len6);
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_DATA_W-1:0] len_word;
        for (int w = 0; w < PAT_REGS; w++)
        begin
            word = {$urandom, $urandom};
            for (int k = 0; k < 8; k++)
                if (w * 8 + k < plan.size())
                    word[k * 8 +: 8] = plan[w * 8 + k];
            cfg_write(REG_PAT_0_7 + w[CFG_IDX_W-1:0], word);
        end
        // junk above the length field
        len_word = {$urandom, $urandom};
        len_word[LEN_REG_W-1:0] = len6;
        cfg_write(REG_PAT_LEN, len_word);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic poke_spare_regs();
        for (int k = REG_SPARE; k < (1 << CFG_IDX_W); k++)
            cfg_write(k[CFG_IDX_W-1:0], {$urandom, $urandom});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // every request accepted and every verdict back, then a short drain
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (reqs_in_flight != 0 || expected_matches.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        byte_q_t              plan;
        logic [LEN_REG_W-1:0] len6;
        int unsigned          placed;

        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        req.valid     = 1'b0;
        req.op        = OP_BYTE;
        req.name_byte = '0;
        rsp.ready     = 1'b0;
        pat_words     = '{default: '0};
        len_reg       = '0;
        live_set      = live_set_t'(1);
        send_idle_pct = 31;
        recv_idle_pct = 68;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty name against the empty pattern from reset, then a one-byte name
        push_req(OP_END, 8'h00);
        push_req(OP_BYTE, 8'hFF);
        push_req(OP_END, 8'hFF);
        wait_quiet();

        // star-only pattern: empty name fits, a star in the name is just a byte
        program_pattern(text_bytes("**"), 6'd2);
        push_req(OP_END, 8'h00);
        push_req(OP_BYTE, CHAR_STAR);
        push_req(OP_END, 8'h00);
        wait_quiet();

        // extreme literal bytes around a single-byte wildcard
        plan = {8'hFF, CHAR_ONE, 8'h00};
        program_pattern(plan, 6'd3);
        push_req(OP_BYTE, 8'hFF);
        push_req(OP_BYTE, 8'h00);
        push_req(OP_BYTE, 8'h00);
        push_req(OP_END, 8'hFF);
        push_req(OP_BYTE, 8'hFF);
        push_req(OP_BYTE, 8'h00);
        push_req(OP_END, 8'h00);
        wait_quiet();

        // star run containing a star, then a name left open across a pattern change
        program_pattern(text_bytes("a?*b"), 6'd4);
        push_req(OP_BYTE, byte_t'("a"));
        push_req(OP_BYTE, CHAR_STAR);
        push_req(OP_BYTE, byte_t'("x"));
        push_req(OP_BYTE, byte_t'("b"));
        push_req(OP_END, 8'h00);
        push_req(OP_BYTE, byte_t'("a"));
        wait_quiet();

        // spare indexes must leave the pattern alone
        poke_spare_regs();
        program_pattern(text_bytes("?z"), 6'd2);
        poke_spare_regs();
        push_req(OP_BYTE, byte_t'("z"));
        push_req(OP_END, 8'h00);
        wait_quiet();

        // length field at its top value saturates to the maximum
        plan = {};
        repeat (PMAX) plan.insert(plan.size(), CHAR_STAR);
        program_pattern(plan, 6'h3F);
        push_req(OP_END, 8'h00);
        push_req(OP_BYTE, 8'h00);
        push_req(OP_END, 8'hFF);
        wait_quiet();

        // random patterns, each with a batch of names; idling profile shifts
        // by thirds and two phases get a long receiver hold-off
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == RANDOM_PHASES / 3)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 31;
            end
            if (ph == 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            plan = random_pattern(len6);
            program_pattern(plan, len6);
            if ($urandom_range(7, 0) == 0)
                poke_spare_regs();
            if (ph == 4 || ph == RANDOM_PHASES - 2)
                hold_kicks++;
            placed = 0;
            while (placed < PHASE_REQS)
                placed += queue_name(plan);
            // now and then leave a name open so the next pattern lands mid-name
            if ($urandom_range(9, 0) == 0)
                repeat ($urandom_range(3, 1))
                    push_req(OP_BYTE, pick_name_byte());
            wait_quiet();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
